// ===== src/mpa_pkg.sv =====
`timescale 1ns / 1ps
// mpa_pkg: shared constants, register indexes, controller states and the
// command/status structs of the max pool argmax unit. No dependencies.
package mpa_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_CHANNELS = 64;
    localparam int MAX_KERNEL   = 4;
    localparam int VALUE_BITS   = 16;

    localparam int SLOT_BITS = $clog2(MAX_KERNEL);
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int CH_BITS   = $clog2(MAX_CHANNELS);
    localparam int ADDR_BITS = SLOT_BITS + COL_BITS + CH_BITS;
    localparam int DEPTH     = 1 << ADDR_BITS;

    localparam int ROW_BITS  = 10;
    localparam int IMG_BITS  = 16;
    localparam int IDX_BITS  = 24;
    localparam int CFG_BITS  = 11;
    localparam int DIV_STEPS = ROW_BITS;

    typedef enum logic [2:0] {
        REG_IN_HEIGHT     = 3'd0,
        REG_IN_WIDTH      = 3'd1,
        REG_CHANNEL_COUNT = 3'd2,
        REG_KERNEL_SIZE   = 3'd3,
        REG_STRIDE        = 3'd4
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_DIV,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic mem_write;
        logic div_start;
        logic div_step;
        logic scan_start;
        logic scan_step;
        logic mul;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic candidate;
        logic div_done;
        logic aligned;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

// ===== src/mpa_ctrl.sv =====
`timescale 1ns / 1ps
// mpa_ctrl: sequencer of the max pool argmax unit
// depends on mpa_pkg
module mpa_ctrl
    import mpa_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_WRITE;
            end
            ST_WRITE: begin
                state_next = status.candidate ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (status.div_done) state_next = status.aligned ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (status.scan_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_MUL;
            ST_MUL:   state_next = ST_EMIT;
            ST_EMIT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_WRITE: begin
                cmd.mem_write = 1'b1;
                cmd.div_start = status.candidate;
            end
            ST_DIV: begin
                cmd.div_step   = !status.div_done;
                cmd.scan_start = status.div_done && status.aligned;
            end
            ST_SCAN:  cmd.scan_step = 1'b1;
            ST_DRAIN: cmd = '0;
            ST_MUL:   cmd.mul = 1'b1;
            ST_EMIT:  cmd.load_out = status.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

// ===== src/mpa_datapath.sv =====
`timescale 1ns / 1ps
// mpa_datapath: config registers, positions, line store, divider, window scan
// and output register; depends on mpa_pkg
module mpa_datapath
    import mpa_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [2:0]                  cfg_index,
    input  logic [CFG_BITS-1:0]         cfg_data,
    input  logic signed [VALUE_BITS-1:0] s_sample_value,
    input  cmd_t                        cmd,
    output status_t                     status,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [VALUE_BITS-1:0] m_pooled_value,
    output logic [IDX_BITS-1:0]         m_argmax_index,
    output logic [IMG_BITS-1:0]         m_image_number,
    output logic [ROW_BITS-1:0]         m_out_row,
    output logic [COL_BITS-1:0]         m_out_col,
    output logic [CH_BITS-1:0]          m_out_channel,
    output logic                        m_last_of_image
);

    logic [10:0] in_height_reg;
    logic [8:0]  in_width_reg;
    logic [6:0]  channel_count_reg;
    logic [2:0]  kernel_size_reg;
    logic [2:0]  stride_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_height_reg     <= 11'd1;
            in_width_reg      <= 9'd1;
            channel_count_reg <= 7'd1;
            kernel_size_reg   <= 3'd2;
            stride_reg        <= 3'd2;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IN_HEIGHT:     in_height_reg     <= cfg_data[10:0];
                REG_IN_WIDTH:      in_width_reg      <= cfg_data[8:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[6:0];
                REG_KERNEL_SIZE:   kernel_size_reg   <= cfg_data[2:0];
                REG_STRIDE:        stride_reg        <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // effective sizes
    logic [10:0] h_eff;
    logic [8:0]  w_eff;
    logic [6:0]  c_eff;
    logic [2:0]  k_eff;
    logic [2:0]  s_eff;

    always_comb begin
        h_eff = (in_height_reg == 11'd0) ? 11'd1 :
                (in_height_reg > 11'd1024) ? 11'd1024 : in_height_reg;
        w_eff = (in_width_reg == 9'd0) ? 9'd1 :
                (in_width_reg > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : in_width_reg;
        c_eff = (channel_count_reg == 7'd0) ? 7'd1 :
                (channel_count_reg > 7'(MAX_CHANNELS)) ? 7'(MAX_CHANNELS)
                                                        : channel_count_reg;
        k_eff = (kernel_size_reg == 3'd0) ? 3'd1 :
                (kernel_size_reg > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kernel_size_reg;
        s_eff = (stride_reg == 3'd0) ? 3'd1 : stride_reg;
    end

    // status bits
    logic candidate;
    logic div_done;
    logic aligned;
    logic scan_last;
    logic out_free;

    assign status = '{candidate: candidate, div_done: div_done, aligned: aligned,
                      scan_last: scan_last, out_free: out_free};

    // positions
    logic [ROW_BITS-1:0] row_pos_reg;
    logic [COL_BITS-1:0] col_pos_reg;
    logic [CH_BITS-1:0]  ch_pos_reg;
    logic [IMG_BITS-1:0] img_reg;
    logic [ROW_BITS-1:0] cur_r_reg;
    logic [COL_BITS-1:0] cur_c_reg;
    logic [CH_BITS-1:0]  cur_ch_reg;
    logic [IMG_BITS-1:0] cur_img_reg;
    logic signed [VALUE_BITS-1:0] sample_reg;

    logic                wrap;
    logic [ROW_BITS-1:0] r_in;
    logic [COL_BITS-1:0] c_in;
    logic [CH_BITS-1:0]  ch_in;
    logic                ch_end, col_end, row_end;

    always_comb begin
        wrap  = ({1'b0, row_pos_reg} >= h_eff) || ({1'b0, col_pos_reg} >= w_eff) ||
                ({1'b0, ch_pos_reg} >= c_eff);
        r_in  = wrap ? '0 : row_pos_reg;
        c_in  = wrap ? '0 : col_pos_reg;
        ch_in = wrap ? '0 : ch_pos_reg;
        ch_end  = ({1'b0, ch_in} + 7'd1) >= c_eff;
        col_end = ({1'b0, c_in} + 9'd1) >= w_eff;
        row_end = ({1'b0, r_in} + 11'd1) >= h_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            ch_pos_reg  <= '0;
            img_reg     <= '0;
        end else if (cmd.accept) begin
            if (!ch_end) begin
                row_pos_reg <= r_in;
                col_pos_reg <= c_in;
                ch_pos_reg  <= ch_in + 1'b1;
            end else if (!col_end) begin
                row_pos_reg <= r_in;
                col_pos_reg <= c_in + 1'b1;
                ch_pos_reg  <= '0;
            end else if (!row_end) begin
                row_pos_reg <= r_in + 1'b1;
                col_pos_reg <= '0;
                ch_pos_reg  <= '0;
            end else begin
                row_pos_reg <= '0;
                col_pos_reg <= '0;
                ch_pos_reg  <= '0;
                img_reg     <= img_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cur_r_reg   <= r_in;
            cur_c_reg   <= c_in;
            cur_ch_reg  <= ch_in;
            cur_img_reg <= img_reg;
            sample_reg  <= s_sample_value;
        end
    end

    // window origin
    logic [ROW_BITS-1:0] r0;
    logic [ROW_BITS-1:0] c0;

    always_comb begin
        r0 = cur_r_reg + 10'd1 - {7'd0, k_eff};
        c0 = {2'd0, cur_c_reg} + 10'd1 - {7'd0, k_eff};
        candidate = ({1'b0, cur_r_reg} + 11'd1 >= {8'd0, k_eff}) &&
                    ({1'b0, cur_c_reg} + 9'd1 >= {6'd0, k_eff});
    end

    // restoring dividers for row and column origin
    logic [2:0]          rem_r_reg, rem_c_reg;
    logic [ROW_BITS-1:0] q_r_reg, q_c_reg;
    logic [3:0]          div_cnt_reg;
    logic [3:0]          t_r, t_c;

    always_comb begin
        t_r = {rem_r_reg, q_r_reg[ROW_BITS-1]};
        t_c = {rem_c_reg, q_c_reg[ROW_BITS-1]};
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_r_reg   <= '0;
            rem_c_reg   <= '0;
            q_r_reg     <= r0;
            q_c_reg     <= c0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (t_r >= {1'b0, s_eff}) begin
                rem_r_reg <= 3'(t_r - {1'b0, s_eff});
                q_r_reg   <= {q_r_reg[ROW_BITS-2:0], 1'b1};
            end else begin
                rem_r_reg <= t_r[2:0];
                q_r_reg   <= {q_r_reg[ROW_BITS-2:0], 1'b0};
            end
            if (t_c >= {1'b0, s_eff}) begin
                rem_c_reg <= 3'(t_c - {1'b0, s_eff});
                q_c_reg   <= {q_c_reg[ROW_BITS-2:0], 1'b1};
            end else begin
                rem_c_reg <= t_c[2:0];
                q_c_reg   <= {q_c_reg[ROW_BITS-2:0], 1'b0};
            end
        end
    end

    assign div_done = (div_cnt_reg == 4'(DIV_STEPS));
    assign aligned  = (rem_r_reg == 3'd0) && (rem_c_reg == 3'd0);

    // window scan
    logic [2:0]          i_reg, j_reg;
    logic [ROW_BITS-1:0] rd_row;
    logic [COL_BITS-1:0] rd_col;
    logic [ROW_BITS-1:0] rd_row_reg, br_reg;
    logic [COL_BITS-1:0] rd_col_reg, bc_reg;
    logic                rd_pend_reg, rd_first_reg;
    logic signed [VALUE_BITS-1:0] mem_q_reg, best_reg;
    logic [ADDR_BITS-1:0] wr_addr, rd_addr;
    logic signed [VALUE_BITS-1:0] mem [DEPTH];

    always_comb begin
        rd_row  = r0 + {7'd0, i_reg};
        rd_col  = COL_BITS'(c0 + {7'd0, j_reg});
        wr_addr = {cur_r_reg[SLOT_BITS-1:0], cur_c_reg, cur_ch_reg};
        rd_addr = {rd_row[SLOT_BITS-1:0], rd_col, cur_ch_reg};
        scan_last = (i_reg == k_eff - 3'd1) && (j_reg == k_eff - 3'd1);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_write) mem[wr_addr] <= sample_reg;
        if (cmd.scan_step) mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            i_reg <= '0;
            j_reg <= '0;
        end else if (cmd.scan_step) begin
            if (j_reg == k_eff - 3'd1) begin
                j_reg <= '0;
                i_reg <= i_reg + 1'b1;
            end else begin
                j_reg <= j_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.scan_step;
        end
    end

    always_ff @(posedge aclk) begin
        rd_first_reg <= (i_reg == 3'd0) && (j_reg == 3'd0);
        rd_row_reg   <= rd_row;
        rd_col_reg   <= rd_col;
        if (rd_pend_reg && (rd_first_reg || mem_q_reg > best_reg)) begin
            best_reg <= mem_q_reg;
            br_reg   <= rd_row_reg;
            bc_reg   <= rd_col_reg;
        end
    end

    // flat index, first half
    logic [18:0] sum1_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul) sum1_reg <= 19'(br_reg * w_eff) + {11'd0, bc_reg};
    end

    // output register
    logic        m_valid_reg;
    logic [25:0] idx_full;
    logic [11:0] row_reach, col_reach;
    logic        last;

    always_comb begin
        idx_full  = 26'(sum1_reg * c_eff) + {20'd0, cur_ch_reg};
        row_reach = {2'd0, r0} + {9'd0, s_eff} + {9'd0, k_eff};
        col_reach = {2'd0, c0} + {9'd0, s_eff} + {9'd0, k_eff};
        last = (row_reach > {1'b0, h_eff}) && (col_reach > {3'd0, w_eff}) &&
               ({1'b0, cur_ch_reg} + 7'd1 == c_eff);
        out_free = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_pooled_value  <= best_reg;
            m_argmax_index  <= idx_full[IDX_BITS-1:0];
            m_image_number  <= cur_img_reg;
            m_out_row       <= q_r_reg;
            m_out_col       <= q_c_reg[COL_BITS-1:0];
            m_out_channel   <= cur_ch_reg;
            m_last_of_image <= last;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== src/max_pool_argmax_nhwc_unit.sv =====
`timescale 1ns / 1ps
// max_pool_argmax_nhwc_unit: top level, 2-D max pooling with argmax over NHWC
// depends on mpa_pkg, mpa_ctrl, mpa_datapath
//
//  channel  ports               transfer
//  input    s_valid/s_ready     one sample, raster order, channel fastest
//  result   m_valid/m_ready     pooled value, argmax index and position
//  config   cfg_valid/cfg_ready register index and data, taken any cycle
//
// a sample that forms no window is only written to the line store; one that forms an
// unaligned window also runs the divider; a pooled window's time is set by the single line store
// read port and the 10 step bit-serial stride divider
// reset is synchronous, active low; the line store is not cleared
// a result waits in the output register while the next sample is taken
module max_pool_argmax_nhwc_unit
    import mpa_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [CFG_BITS-1:0]          cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_sample_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [VALUE_BITS-1:0] m_pooled_value,
    output logic [IDX_BITS-1:0]          m_argmax_index,
    output logic [IMG_BITS-1:0]          m_image_number,
    output logic [ROW_BITS-1:0]          m_out_row,
    output logic [COL_BITS-1:0]          m_out_col,
    output logic [CH_BITS-1:0]           m_out_channel,
    output logic                         m_last_of_image
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    mpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mpa_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_sample_value  (s_sample_value),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pooled_value  (m_pooled_value),
        .m_argmax_index  (m_argmax_index),
        .m_image_number  (m_image_number),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_out_channel   (m_out_channel),
        .m_last_of_image (m_last_of_image)
    );

endmodule

// ===== tb/tb_max_pool_argmax_nhwc_unit.sv =====
`timescale 1ns / 1ps
// tb_max_pool_argmax_nhwc_unit: self-checking testbench of the max pool argmax unit
// depends on mpa_pkg and max_pool_argmax_nhwc_unit; a directed table, then random
// images under several register settings, checked against typed rows or the predictor
module tb_max_pool_argmax_nhwc_unit;
    import mpa_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [15:0] pooled;
        logic [23:0] argmax;
        logic [15:0] image;
        logic [9:0]  orow;
        logic [7:0]  ocol;
        logic [5:0]  chan;
        logic        last;
    } pool_res_t;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        reg_index_t idx;
        int         data;
        bit         typed;
        pool_res_t  res;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [VALUE_BITS-1:0] s_sample_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [VALUE_BITS-1:0] m_pooled_value;
    logic [IDX_BITS-1:0] m_argmax_index;
    logic [IMG_BITS-1:0] m_image_number;
    logic [ROW_BITS-1:0] m_out_row;
    logic [COL_BITS-1:0] m_out_col;
    logic [CH_BITS-1:0] m_out_channel;
    logic m_last_of_image;

    max_pool_argmax_nhwc_unit u_dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [15:0] pool_mem [0:65535];
    int unsigned rg_height = 1, rg_width = 1, rg_chans = 1, rg_kernel = 2, rg_stride = 2;
    int unsigned pos_row = 0, pos_col = 0, pos_ch = 0;
    logic [15:0] img_count = '0;
    pool_res_t pooled_q [$];

    bit cur_typed = 1'b0;
    pool_res_t cur_res;
    int errors = 0;
    int idle_pct = 0, stall_pct = 0, hold_cycles = 0;
    int items_sent = 0, idle_count = 0;

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic logic [15:0] mem_addr(int unsigned r, int unsigned c, int unsigned ch);
        return 16'((((r % 4) * 256 + c) * 64 + ch) % 65536);
    endfunction

    function automatic bit pool_predict(input logic [15:0] v, output pool_res_t r);
        int unsigned h, w, c, k, s, r0, c0, br, bc;
        logic signed [15:0] best, cand;
        bit hit;
        h = clampu(rg_height, 1, 1024);
        w = clampu(rg_width, 1, 256);
        c = clampu(rg_chans, 1, 64);
        k = clampu(rg_kernel, 1, 4);
        s = clampu(rg_stride, 1, 7);
        hit = 1'b0;
        r = '0;
        if (pos_row >= h || pos_col >= w || pos_ch >= c) begin
            pos_row = 0;
            pos_col = 0;
            pos_ch = 0;
        end
        pool_mem[mem_addr(pos_row, pos_col, pos_ch)] = v;
        if (pos_row + 1 >= k && pos_col + 1 >= k) begin
            r0 = pos_row + 1 - k;
            c0 = pos_col + 1 - k;
            if (r0 % s == 0 && c0 % s == 0) begin
                best = pool_mem[mem_addr(r0, c0, pos_ch)];
                br = r0;
                bc = c0;
                for (int i = 0; i < k; i++) begin
                    for (int j = 0; j < k; j++) begin
                        cand = pool_mem[mem_addr(r0 + i, c0 + j, pos_ch)];
                        if (cand > best) begin
                            best = cand;
                            br = r0 + i;
                            bc = c0 + j;
                        end
                    end
                end
                r.pooled = best;
                r.argmax = 24'((br * w + bc) * c + pos_ch);
                r.image = img_count;
                r.orow = 10'(r0 / s);
                r.ocol = 8'(c0 / s);
                r.chan = 6'(pos_ch);
                r.last = (r0 / s == (h - k) / s) && (c0 / s == (w - k) / s) && (pos_ch + 1 == c);
                hit = 1'b1;
            end
        end
        pos_ch++;
        if (pos_ch >= c) begin
            pos_ch = 0;
            pos_col++;
            if (pos_col >= w) begin
                pos_col = 0;
                pos_row++;
                if (pos_row >= h) begin
                    pos_row = 0;
                    img_count++;
                end
            end
        end
        return hit;
    endfunction

    // monitor: track config writes, predict on every input transfer, check every result transfer
    always @(posedge aclk) begin
        pool_res_t pr, got, want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_IN_HEIGHT:     rg_height = 32'(cfg_data & 11'h7FF);
                    REG_IN_WIDTH:      rg_width = 32'(cfg_data & 11'h1FF);
                    REG_CHANNEL_COUNT: rg_chans = 32'(cfg_data & 11'h7F);
                    REG_KERNEL_SIZE:   rg_kernel = 32'(cfg_data & 11'h7);
                    REG_STRIDE:        rg_stride = 32'(cfg_data & 11'h7);
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (pool_predict(s_sample_value, pr))
                    pooled_q.push_back(cur_typed ? cur_res : pr);
            end
            if (m_valid && m_ready) begin
                got = {m_pooled_value, m_argmax_index, m_image_number, m_out_row,
                       m_out_col, m_out_channel, m_last_of_image};
                if (pooled_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result %h", $time, got);
                end else begin
                    want = pooled_q.pop_front();
                    if (got.pooled !== want.pooled) begin
                        errors++;
                        $display("%0t pooled_value exp %h got %h", $time, want.pooled, got.pooled);
                    end
                    if (got.argmax !== want.argmax) begin
                        errors++;
                        $display("%0t argmax_index exp %h got %h", $time, want.argmax, got.argmax);
                    end
                    if (got.image !== want.image) begin
                        errors++;
                        $display("%0t image_number exp %h got %h", $time, want.image, got.image);
                    end
                    if (got.orow !== want.orow) begin
                        errors++;
                        $display("%0t out_row exp %h got %h", $time, want.orow, got.orow);
                    end
                    if (got.ocol !== want.ocol) begin
                        errors++;
                        $display("%0t out_col exp %h got %h", $time, want.ocol, got.ocol);
                    end
                    if (got.chan !== want.chan) begin
                        errors++;
                        $display("%0t out_channel exp %h got %h", $time, want.chan, got.chan);
                    end
                    if (got.last !== want.last) begin
                        errors++;
                        $display("%0t last_of_image exp %h got %h", $time, want.last, got.last);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) || !aresetn)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver with random stalls and a long hold-off on request
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_sample(input logic [15:0] v, input bit typed, input pool_res_t res);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(0, 99) < idle_pct) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_value <= v;
        cur_typed <= typed;
        cur_res <= res;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_BITS'(data);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        cfg_valid <= 1'b0;
        @(negedge aclk);
        wait (pooled_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // bring positions back to the image origin, then load all five registers
    task automatic set_config(input int h, input int w, input int c, input int k, input int s);
        pool_res_t none;
        none = '0;
        wait_idle();
        if (pos_row != 0 || pos_col != 0 || pos_ch != 0) begin
            write_reg(REG_IN_HEIGHT, 1);
            write_reg(REG_IN_WIDTH, 1);
            write_reg(REG_CHANNEL_COUNT, 1);
            cfg_valid <= 1'b0;
            send_sample(16'($urandom), 1'b0, none);
            wait_idle();
        end
        write_reg(REG_IN_HEIGHT, h);
        write_reg(REG_IN_WIDTH, w);
        write_reg(REG_CHANNEL_COUNT, c);
        write_reg(REG_KERNEL_SIZE, k);
        write_reg(REG_STRIDE, s);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_value();
        if ($urandom_range(0, 99) < 60) return 16'($urandom_range(0, 3)) - 16'd2;
        return 16'($urandom);
    endfunction

    task automatic run_sweep(input int n);
        pool_res_t none;
        none = '0;
        for (int i = 0; i < n; i++) send_sample(rand_value(), 1'b0, none);
    endtask

    function automatic stim_row_t cfg_row(input reg_index_t idx, input int data);
        stim_row_t r;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        r.typed = 1'b0;
        r.res = '0;
        return r;
    endfunction

    function automatic stim_row_t smp_row(input int v);
        stim_row_t r;
        r.kind = ROW_SAMPLE;
        r.idx = REG_IN_HEIGHT;
        r.data = v;
        r.typed = 1'b0;
        r.res = '0;
        return r;
    endfunction

    // unit window: result is the sample itself at index zero, every image ends
    function automatic stim_row_t unit_row(input int v, input int img);
        stim_row_t r;
        r = smp_row(v);
        r.typed = 1'b1;
        r.res = '{pooled: 16'(v), argmax: 24'd0, image: 16'(img), orow: 10'd0, ocol: 8'd0,
                  chan: 6'd0, last: 1'b1};
        return r;
    endfunction

    initial begin
        stim_row_t dir_tab [$];
        logic [15:0] tie_vals [8];
        int h, w, c, k, s, n, phase;
        for (int i = 0; i < 65536; i++) pool_mem[16'(i)] = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // image smaller than the reset kernel gives nothing
        dir_tab.push_back(smp_row(16'h1234));
        dir_tab.push_back(cfg_row(REG_KERNEL_SIZE, 1));
        dir_tab.push_back(cfg_row(REG_STRIDE, 1));
        dir_tab.push_back(unit_row(16'h7FFF, 1));
        dir_tab.push_back(unit_row(16'h8000, 2));
        dir_tab.push_back(unit_row(16'h0000, 3));
        dir_tab.push_back(unit_row(16'hFFFF, 4));
        dir_tab.push_back(unit_row(16'h0100, 5));
        // 2x2x2 image, kernel 2: ties keep the first maximum
        dir_tab.push_back(cfg_row(REG_IN_HEIGHT, 2));
        dir_tab.push_back(cfg_row(REG_IN_WIDTH, 2));
        dir_tab.push_back(cfg_row(REG_CHANNEL_COUNT, 2));
        dir_tab.push_back(cfg_row(REG_KERNEL_SIZE, 2));
        tie_vals = '{16'h0005, 16'hFFFF, 16'h0005, 16'h0007, 16'h0005, 16'h0007,
                     16'h0005, 16'h8000};
        foreach (tie_vals[i])
            dir_tab.push_back(smp_row(int'(tie_vals[i])));
        // zero registers act as one
        dir_tab.push_back(cfg_row(REG_KERNEL_SIZE, 0));
        dir_tab.push_back(cfg_row(REG_STRIDE, 0));
        dir_tab.push_back(smp_row(16'h4242));

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
                cfg_valid <= 1'b0;
                @(negedge aclk);
            end else begin
                send_sample(16'(dir_tab[i].data), dir_tab[i].typed, dir_tab[i].res);
            end
        end

        // sweeps that walk the column and channel fields to their tops
        set_config(1, 256, 1, 1, 1);
        run_sweep(256);
        set_config(1, 1, 64, 1, 1);
        run_sweep(64);
        // out-of-range raw values, partial images
        set_config(2047, 511, 127, 7, 7);
        run_sweep(150);
        set_config(2047, 6, 1, 4, 7);
        run_sweep(150);

        phase = 0;
        while (items_sent < 1600 || phase < 6) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            h = $urandom_range(1, 8);
            w = $urandom_range(1, 10);
            c = $urandom_range(1, 4);
            k = $urandom_range(1, 4);
            s = $urandom_range(1, 7);
            if ($urandom_range(0, 7) == 0) s = 0;
            if ($urandom_range(0, 7) == 0) k = 0;
            if (phase == 5) begin
                k = 1;
                s = 1;
            end
            set_config(h, w, c, k, s);
            if (phase == 5) hold_cycles = 400;
            n = h * w * c * $urandom_range(1, 3);
            if ($urandom_range(0, 5) == 0) n = n + $urandom_range(1, 5);
            if (phase == 5) n = n + 40;
            run_sweep(n);
            phase++;
        end

        wait_idle();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
